### hw/rtl/qbpe_pkg.sv
// Shared widths and constants of the quintic Bezier evaluator.
// No dependencies; used by qbpe_div_pipe and quintic_bezier_pvaj_eval.
package qbpe_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int PT_W     = 32;   // control point width
    localparam int DUR_W    = 32;   // segment duration width
    localparam int PHASE_W  = 17;   // phase width
    localparam int OUT_W    = 48;   // result field width

    localparam int D1_W     = 33;   // first difference
    localparam int D2_W     = 34;   // second difference
    localparam int D3_W     = 35;   // third difference

    localparam int M_W      = 63;   // scaled magnitude, 0 .. 2^62
    localparam int Q_BITS   = 62;   // quotient bits below the cap

    localparam int IN_TDATA_W  = 248;
    localparam int OUT_TDATA_W = 192;

    localparam logic [M_W-1:0] STAGE_CAP = M_W'(1) << Q_BITS;

    localparam logic [M_W-1:0] K_VEL  = M_W'(5);
    localparam logic [M_W-1:0] K_ACC  = M_W'(20);
    localparam logic [M_W-1:0] K_JERK = M_W'(60);

endpackage

### hw/rtl/qbpe_div_pipe.sv
// Pipelined rounding divider: res = min(floor((m * 2^F + d/2) / d), 2^62),
// one quotient bit per stage over one or more lanes sharing one divisor. Uses qbpe_pkg.
module qbpe_div_pipe
    import qbpe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int LANES     = 1,
    parameter int SW        = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [LANES-1:0][M_W-1:0]   i_m,
    input  logic [DUR_W-1:0]            i_d,
    input  logic [SW-1:0]               i_side,
    output logic                        o_vld,
    output logic [LANES-1:0][M_W-1:0]   o_res,
    output logic [DUR_W-1:0]            o_d,
    output logic [SW-1:0]               o_side
);

    localparam int NW = M_W + FRAC_BITS + 1;
    localparam int HW = NW - Q_BITS;

    logic                              r_vld  [0:Q_BITS];
    logic [LANES-1:0][DUR_W-1:0]       r_rem  [0:Q_BITS];
    logic [LANES-1:0][Q_BITS-1:0]      r_x    [0:Q_BITS];
    logic [LANES-1:0]                  r_sat  [0:Q_BITS];
    logic [DUR_W-1:0]                  r_d    [0:Q_BITS];
    logic [SW-1:0]                     r_side [0:Q_BITS];

    logic [LANES-1:0][DUR_W-1:0]       n_rem0;
    logic [LANES-1:0][Q_BITS-1:0]      n_x0;
    logic [LANES-1:0]                  n_sat0;

    // Front: build the dividend and catch a quotient at or above the cap
    always_comb begin
        logic [NW-1:0] num;
        logic [HW-1:0] hi;
        for (int l = 0; l < LANES; l++) begin
            num       = (NW'(i_m[l]) << FRAC_BITS) + NW'(i_d[DUR_W-1:1]);
            hi        = num[NW-1:Q_BITS];
            n_sat0[l] = i_m[l][M_W-1] | (64'(hi) >= 64'(i_d));
            n_rem0[l] = DUR_W'(hi);
            n_x0[l]   = num[Q_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_rem0;
            r_x[0]    <= n_x0;
            r_sat[0]  <= n_sat0;
            r_d[0]    <= i_d;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < Q_BITS; k++) begin : g_it
        logic [LANES-1:0][DUR_W-1:0]  n_rem;
        logic [LANES-1:0][Q_BITS-1:0] n_x;

        // Shift in the next dividend bit, subtract where it fits
        always_comb begin
            logic [DUR_W:0] t;
            for (int l = 0; l < LANES; l++) begin
                t = {r_rem[k][l], r_x[k][l][Q_BITS-1]};
                if (t >= {1'b0, r_d[k]}) begin
                    n_rem[l] = DUR_W'(t - {1'b0, r_d[k]});
                    n_x[l]   = {r_x[k][l][Q_BITS-2:0], 1'b1};
                end else begin
                    n_rem[l] = t[DUR_W-1:0];
                    n_x[l]   = {r_x[k][l][Q_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_x[k+1]    <= n_x;
                r_sat[k+1]  <= r_sat[k];
                r_d[k+1]    <= r_d[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_res[l] = r_sat[Q_BITS][l] ? STAGE_CAP : {1'b0, r_x[Q_BITS][l]};
        end
    end

    assign o_vld  = r_vld[Q_BITS];
    assign o_d    = r_d[Q_BITS];
    assign o_side = r_side[Q_BITS];

endmodule

### hw/rtl/quintic_bezier_pvaj_eval.sv
// Quintic Bezier evaluator, one axis: position, velocity, acceleration, jerk.
// Depends on qbpe_pkg and qbpe_div_pipe.
//
// Usage:
//   Send one request per axis sample on s_axis: six control points, the
//   segment duration and the phase. One result comes back on m_axis for
//   each request, in order: position, velocity, acceleration and jerk.
//   The pipeline is an input register, five de Casteljau levels, a
//   magnitude stage, three rounds of 63-stage bit-serial dividers (one
//   round per power of the duration) and the output register. Throughput is
//   one request per cycle unless frozen; the divider stages set the depth.
//   Reset clears the valid bits only; the pipeline starts empty.
//   When the receiver stalls and the output register is full, the pipeline
//   keeps moving while its last stage holds a bubble, and freezes as a
//   whole once a result reaches that stage. s_axis_tready falls while frozen.
module quintic_bezier_pvaj_eval
    import qbpe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // ctrl_pt0..ctrl_pt5 [191:0], seg_duration [223:192], phase [240:224], zero pad
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // position [47:0], velocity [95:48], acceleration [143:96], jerk_out [191:144]
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int UW   = FRAC_BITS + 1;
    localparam int PEW  = (UW > PHASE_W) ? UW : PHASE_W;
    localparam int PRW  = D1_W + UW + 1;
    localparam int SW1  = PT_W + 3;
    localparam int SW2  = SW1 + M_W;
    localparam int SW3  = SW2 + M_W;

    localparam logic [PEW-1:0] U_ONE = PEW'(1) << FRAC_BITS;
    localparam logic signed [PRW-1:0] RND = PRW'(1) << (FRAC_BITS - 1);
    localparam logic [M_W-1:0] OUT_MAX_M = M_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic [M_W-1:0] OUT_MIN_M = M_W'(1) << (OUT_W - 1);

    function automatic logic signed [PT_W-1:0] lerp(
        input logic signed [PT_W-1:0] a,
        input logic signed [PT_W-1:0] b,
        input logic [UW-1:0]          u
    );
        logic signed [D1_W-1:0] df;
        logic signed [PRW-1:0]  pr;
        logic signed [PRW-1:0]  sh;
        df = {b[PT_W-1], b} - {a[PT_W-1], a};
        pr = df * $signed({1'b0, u}) + RND;
        sh = pr >>> FRAC_BITS;
        return a + sh[PT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [M_W-1:0] m);
        logic [OUT_W-1:0] v;
        if (neg) begin
            v = (m > OUT_MIN_M) ? OUT_MIN_M[OUT_W-1:0] : (~m[OUT_W-1:0] + OUT_W'(1));
        end else begin
            v = (m > OUT_MAX_M) ? OUT_MAX_M[OUT_W-1:0] : m[OUT_W-1:0];
        end
        return v;
    endfunction

    logic en;
    logic out_free;
    logic r3_vld;

    // Stage 0 is the input register, stages 1..5 the de Casteljau levels
    logic                   r_vld [0:5];
    logic signed [PT_W-1:0] r_pt  [0:5][0:5];
    logic [UW-1:0]          r_u   [0:5];
    logic [DUR_W-1:0]       r_dur [0:5];
    logic signed [D3_W-1:0] r_d3  [3:5];
    logic signed [D2_W-1:0] r_d2  [4:5];
    logic signed [D1_W-1:0] r_d1;

    logic [PEW-1:0]   n_phase;
    logic [DUR_W-1:0] n_dur;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign en            = out_free || !r3_vld;
    assign s_axis_tready = en;

    assign n_phase = PEW'(s_axis_tdata[240:224]);
    assign n_dur   = (s_axis_tdata[223:192] == '0) ? DUR_W'(1) : s_axis_tdata[223:192];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 6; s++) r_vld[s] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int s = 1; s < 6; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                r_pt[0][i] <= s_axis_tdata[PT_W*i +: PT_W];
            end
            r_u[0]   <= (n_phase > U_ONE) ? UW'(U_ONE) : UW'(n_phase);
            r_dur[0] <= n_dur;
        end
    end

    for (genvar s = 1; s < 6; s++) begin : g_lvl
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 6 - s; i++) begin
                    r_pt[s][i] <= lerp(r_pt[s-1][i], r_pt[s-1][i+1], r_u[s-1]);
                end
                r_u[s]   <= r_u[s-1];
                r_dur[s] <= r_dur[s-1];
            end
        end
    end

    // Differences come from the four-, three- and two-point levels
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3[3] <= D3_W'(r_pt[2][3]) - D3_W'(r_pt[2][2]) - D3_W'(r_pt[2][2])
                     - D3_W'(r_pt[2][2]) + D3_W'(r_pt[2][1]) + D3_W'(r_pt[2][1])
                     + D3_W'(r_pt[2][1]) - D3_W'(r_pt[2][0]);
            r_d3[4] <= r_d3[3];
            r_d3[5] <= r_d3[4];
            r_d2[4] <= D2_W'(r_pt[3][2]) - D2_W'(r_pt[3][1]) - D2_W'(r_pt[3][1])
                     + D2_W'(r_pt[3][0]);
            r_d2[5] <= r_d2[4];
            r_d1    <= D1_W'(r_pt[4][1]) - D1_W'(r_pt[4][0]);
        end
    end

    // Magnitude stage: take the sign off and apply the constant
    logic                   r6_vld;
    logic [2:0][M_W-1:0]    r6_m;
    logic [2:0]             r6_neg;
    logic signed [PT_W-1:0] r6_pos;
    logic [DUR_W-1:0]       r6_dur;

    logic [D1_W-1:0] n_a1;
    logic [D2_W-1:0] n_a2;
    logic [D3_W-1:0] n_a3;

    assign n_a1 = r_d1[D1_W-1]    ? D1_W'(-r_d1)    : D1_W'(r_d1);
    assign n_a2 = r_d2[5][D2_W-1] ? D2_W'(-r_d2[5]) : D2_W'(r_d2[5]);
    assign n_a3 = r_d3[5][D3_W-1] ? D3_W'(-r_d3[5]) : D3_W'(r_d3[5]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r_vld[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_m[0] <= M_W'(n_a1) * K_VEL;
            r6_m[1] <= M_W'(n_a2) * K_ACC;
            r6_m[2] <= M_W'(n_a3) * K_JERK;
            r6_neg  <= {r_d3[5][D3_W-1], r_d2[5][D2_W-1], r_d1[D1_W-1]};
            r6_pos  <= r_pt[5][0];
            r6_dur  <= r_dur[5];
        end
    end

    logic                  r1_vld;
    logic [2:0][M_W-1:0]   r1_res;
    logic [DUR_W-1:0]      r1_dur;
    logic [SW1-1:0]        r1_side;

    qbpe_div_pipe #(.FRAC_BITS(FRAC_BITS), .LANES(3), .SW(SW1)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r6_vld),
        .i_m     (r6_m),
        .i_d     (r6_dur),
        .i_side  ({r6_pos, r6_neg}),
        .o_vld   (r1_vld),
        .o_res   (r1_res),
        .o_d     (r1_dur),
        .o_side  (r1_side)
    );

    logic                  r2_vld;
    logic [1:0][M_W-1:0]   r2_res;
    logic [DUR_W-1:0]      r2_dur;
    logic [SW2-1:0]        r2_side;

    qbpe_div_pipe #(.FRAC_BITS(FRAC_BITS), .LANES(2), .SW(SW2)) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r1_vld),
        .i_m     ({r1_res[2], r1_res[1]}),
        .i_d     (r1_dur),
        .i_side  ({r1_res[0], r1_side}),
        .o_vld   (r2_vld),
        .o_res   (r2_res),
        .o_d     (r2_dur),
        .o_side  (r2_side)
    );

    logic [0:0][M_W-1:0]   r3_res;
    logic [DUR_W-1:0]      r3_dur;
    logic [SW3-1:0]        r3_side;

    qbpe_div_pipe #(.FRAC_BITS(FRAC_BITS), .LANES(1), .SW(SW3)) u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r2_vld),
        .i_m     (r2_res[1]),
        .i_d     (r2_dur),
        .i_side  ({r2_res[0], r2_side}),
        .o_vld   (r3_vld),
        .o_res   (r3_res),
        .o_d     (r3_dur),
        .o_side  (r3_side)
    );

    // Side layout, low to high: signs, position, velocity, acceleration
    logic [2:0]             n_neg;
    logic signed [PT_W-1:0] n_pos;
    logic [M_W-1:0]         n_vm;
    logic [M_W-1:0]         n_am;
    logic [OUT_TDATA_W-1:0] n_data;

    assign n_neg  = r3_side[2:0];
    assign n_pos  = r3_side[SW1-1:3];
    assign n_vm   = r3_side[SW2-1:SW1];
    assign n_am   = r3_side[SW3-1:SW2];
    assign n_data = {sat_out(n_neg[2], r3_res[0]),
                     sat_out(n_neg[1], n_am),
                     sat_out(n_neg[0], n_vm),
                     OUT_W'(n_pos)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (out_free) begin
            m_axis_tvalid <= r3_vld;
        end
    end

    // Hold the result while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (out_free && r3_vld && r3_dur != '0) begin
            m_axis_tdata <= n_data;
        end
    end

endmodule
